/* rtl/core/tun_pkg.sv */
// tun_pkg: shared constants and types for the triangle unit normal block.
// No dependencies; compiled first.
package tun_pkg;

  // Default field widths
  localparam int COORD_BITS_DEF = 16;
  localparam int OUT_BITS_DEF   = 16;

  // Configuration register
  localparam int          CFG_BITS       = 32;
  localparam logic [31:0] MIN_NORM_RESET = 32'd1;

  // Flags that ride along the divider cells
  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
  } tun_flags_t;

endpackage

/* rtl/core/tun_ifs.sv */
// tun_ifs: valid/ready channel interfaces for vertices, normals and configuration.
// Depends on tun_pkg.
interface tun_vtx_if #(
  parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] v0_x, v0_y, v0_z;
  logic signed [COORD_BITS-1:0] v1_x, v1_y, v1_z;
  logic signed [COORD_BITS-1:0] v2_x, v2_y, v2_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  input ready);
  modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  output ready);
endinterface

interface tun_nrm_if #(
  parameter int OUT_BITS = tun_pkg::OUT_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] normal_x, normal_y, normal_z;
  logic                       degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

interface tun_cfg_if;
  import tun_pkg::*;
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/tun_front.sv */
// tun_front: edges, cross product, split squares and sum of squares (6 stages).
// Depends on tun_pkg.
module tun_front #(
  parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [8:0][COORD_BITS-1:0]       coords,
  output logic                             out_valid,
  output logic [4*COORD_BITS+3:0]          sum,
  output logic [6*COORD_BITS+8:0]          side
);
  import tun_pkg::*;

  localparam int E = COORD_BITS + 1;
  localparam int P = 2 * E;
  localparam int D = P + 1;
  localparam int M = 2 * E;
  localparam int S = 2 * M;

  logic                v1, v2, v3, v4, v5, v6;
  logic signed [E-1:0] e1 [3];
  logic signed [E-1:0] e2 [3];
  logic signed [P-1:0] prod [6];
  logic [D-1:0]        diff [3];
  logic [D-1:0]        absv [3];
  logic [M-1:0]        mag3 [3];
  logic [M-1:0]        mag4 [3];
  logic [M-1:0]        mag5 [3];
  logic [M-1:0]        mag6 [3];
  logic [2:0]          neg3, neg4, neg5, neg6;
  logic [M-1:0]        hh [3];
  logic [M-1:0]        hl [3];
  logic [M-1:0]        ll [3];
  logic [S-1:0]        sq [3];
  logic [S-1:0]        sum6;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6} <= '0;
    end else if (en) begin
      {v1, v2, v3, v4, v5, v6} <= {in_valid, v1, v2, v3, v4, v5};
    end
  end

  // Cross product differences and magnitudes
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {prod[2*k][P-1], prod[2*k]} - {prod[2*k+1][P-1], prod[2*k+1]};
      absv[k] = diff[k][D-1] ? (~diff[k] + D'(1)) : diff[k];
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // edges from vertex 0
      for (int k = 0; k < 3; k++) begin
        e1[k] <= $signed({coords[3+k][COORD_BITS-1], coords[3+k]})
               - $signed({coords[k][COORD_BITS-1], coords[k]});
        e2[k] <= $signed({coords[6+k][COORD_BITS-1], coords[6+k]})
               - $signed({coords[k][COORD_BITS-1], coords[k]});
      end
      // cross product terms
      prod[0] <= e1[1] * e2[2];
      prod[1] <= e1[2] * e2[1];
      prod[2] <= e1[2] * e2[0];
      prod[3] <= e1[0] * e2[2];
      prod[4] <= e1[0] * e2[1];
      prod[5] <= e1[1] * e2[0];
      // magnitude and sign
      for (int k = 0; k < 3; k++) begin
        mag3[k] <= absv[k][M-1:0];
        neg3[k] <= diff[k][D-1];
      end
      // half-width partial products of each square
      for (int k = 0; k < 3; k++) begin
        hh[k] <= mag3[k][M-1:E] * mag3[k][M-1:E];
        hl[k] <= mag3[k][M-1:E] * mag3[k][E-1:0];
        ll[k] <= mag3[k][E-1:0] * mag3[k][E-1:0];
      end
      mag4 <= mag3;
      neg4 <= neg3;
      // assemble squares
      for (int k = 0; k < 3; k++) begin
        sq[k] <= {hh[k], {M{1'b0}}}
               + {{(M-E-1){1'b0}}, hl[k], {(E+1){1'b0}}}
               + {{M{1'b0}}, ll[k]};
      end
      mag5 <= mag4;
      neg5 <= neg4;
      // sum of squares
      sum6 <= sq[0] + sq[1] + sq[2];
      mag6 <= mag5;
      neg6 <= neg5;
    end
  end

  assign out_valid = v6;
  assign sum       = sum6;
  assign side      = {neg6, mag6[2], mag6[1], mag6[0]};

endmodule

/* rtl/core/tun_sqrt_cell.sv */
// tun_sqrt_cell: one root bit of the integer square root, two radicand bits per cell.
// Depends on tun_pkg.
module tun_sqrt_cell #(
  parameter int RAD_BITS  = 4 * (tun_pkg::COORD_BITS_DEF + 1),
  parameter int ROOT_BITS = 2 * (tun_pkg::COORD_BITS_DEF + 1),
  parameter int SIDE_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [RAD_BITS-1:0]  in_rad,
  input  logic [ROOT_BITS+1:0] in_rem,
  input  logic [ROOT_BITS-1:0] in_root,
  input  logic [SIDE_BITS-1:0] in_side,
  output logic                 out_valid,
  output logic [RAD_BITS-1:0]  out_rad,
  output logic [ROOT_BITS+1:0] out_rem,
  output logic [ROOT_BITS-1:0] out_root,
  output logic [SIDE_BITS-1:0] out_side
);
  import tun_pkg::*;

  logic [ROOT_BITS+1:0] rem_sh;
  logic [ROOT_BITS+1:0] trial;
  logic                 ge;

  // Trial subtraction
  assign rem_sh = {in_rem[ROOT_BITS-1:0], in_rad[RAD_BITS-1:RAD_BITS-2]};
  assign trial  = {in_root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= {in_rad[RAD_BITS-3:0], 2'b00};
      out_rem  <= ge ? (rem_sh - trial) : rem_sh;
      out_root <= {in_root[ROOT_BITS-2:0], ge};
      out_side <= in_side;
    end
  end

endmodule

/* rtl/core/tun_div_cell.sv */
// tun_div_cell: one quotient bit of the three scaled component divisions.
// Depends on tun_pkg (tun_flags_t).
module tun_div_cell #(
  parameter int NORM_BITS = 2 * (tun_pkg::COORD_BITS_DEF + 1),
  parameter int QUOT_BITS = tun_pkg::OUT_BITS_DEF - 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [2:0][NORM_BITS:0]       in_rem,
  input  logic [2:0][QUOT_BITS-1:0]     in_low,
  input  logic [2:0][QUOT_BITS-1:0]     in_quot,
  input  logic [NORM_BITS-1:0]          in_norm,
  input  tun_pkg::tun_flags_t           in_flags,
  output logic                          out_valid,
  output logic [2:0][NORM_BITS:0]       out_rem,
  output logic [2:0][QUOT_BITS-1:0]     out_low,
  output logic [2:0][QUOT_BITS-1:0]     out_quot,
  output logic [NORM_BITS-1:0]          out_norm,
  output tun_pkg::tun_flags_t           out_flags
);
  import tun_pkg::*;

  logic [2:0][NORM_BITS:0] rem_sh;
  logic [2:0]              ge;

  // Shift in next numerator bit and compare with norm, per lane
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_sh[k] = {in_rem[k][NORM_BITS-1:0], in_low[k][QUOT_BITS-1]};
      ge[k]     = (rem_sh[k] >= {1'b0, in_norm});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        out_rem[k]  <= ge[k] ? (rem_sh[k] - {1'b0, in_norm}) : rem_sh[k];
        out_low[k]  <= {in_low[k][QUOT_BITS-2:0], 1'b0};
        out_quot[k] <= {in_quot[k][QUOT_BITS-2:0], ge[k]};
      end
      out_norm  <= in_norm;
      out_flags <= in_flags;
    end
  end

endmodule

/* rtl/core/triangle_unit_normal.sv */
// triangle_unit_normal: unit face normal of one triangle per transaction.
// Pipeline: 6 front stages, one sqrt cell per root bit, a compare stage, one divider
// cell per quotient bit, output register.
// Throughput one triangle per cycle; an output stall freezes the whole pipeline.
// Synchronous reset clears all valid bits and sets min_norm to 1.
module triangle_unit_normal #(
  parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF,
  parameter int OUT_BITS   = tun_pkg::OUT_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  tun_vtx_if.sink   vtx,
  tun_nrm_if.source nrm,
  tun_cfg_if.sink   cfg
);
  import tun_pkg::*;

  localparam int E  = COORD_BITS + 1;
  localparam int M  = 2 * E;
  localparam int S  = 2 * M;
  localparam int R  = M;
  localparam int QW = OUT_BITS - 1;
  localparam int NW = M + QW;
  localparam int CW = (M > CFG_BITS) ? M : CFG_BITS;
  localparam int SW = 3 * M + 3;
  localparam logic [OUT_BITS-1:0] NEG_LIMIT = {1'b1, {QW{1'b0}}};

  logic                en;
  logic [CFG_BITS-1:0] min_norm;

  // Pipeline advances unless the output holds an untaken transaction
  assign en        = !nrm.valid || nrm.ready;
  assign vtx.ready = en;

  // Configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_norm <= MIN_NORM_RESET;
    end else if (cfg.valid && cfg.ready) begin
      min_norm <= cfg.data;
    end
  end

  // Front: cross product and sum of squares
  logic [8:0][COORD_BITS-1:0] coords;
  logic                       f_valid;
  logic [S-1:0]               f_sum;
  logic [SW-1:0]              f_side;

  assign coords = {vtx.v2_z, vtx.v2_y, vtx.v2_x, vtx.v1_z, vtx.v1_y, vtx.v1_x,
                   vtx.v0_z, vtx.v0_y, vtx.v0_x};

  tun_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vtx.valid && vtx.ready),
    .coords    (coords),
    .out_valid (f_valid),
    .sum       (f_sum),
    .side      (f_side)
  );

  // Square root chain
  logic          sq_valid [R+1];
  logic [S-1:0]  sq_rad   [R+1];
  logic [R+1:0]  sq_rem   [R+1];
  logic [R-1:0]  sq_root  [R+1];
  logic [SW-1:0] sq_side  [R+1];

  assign sq_valid[0] = f_valid;
  assign sq_rad[0]   = f_sum;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = f_side;

  for (genvar g = 0; g < R; g++) begin : g_sqrt
    tun_sqrt_cell #(.RAD_BITS(S), .ROOT_BITS(R), .SIDE_BITS(SW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_valid[g]),
      .in_rad    (sq_rad[g]),
      .in_rem    (sq_rem[g]),
      .in_root   (sq_root[g]),
      .in_side   (sq_side[g]),
      .out_valid (sq_valid[g+1]),
      .out_rad   (sq_rad[g+1]),
      .out_rem   (sq_rem[g+1]),
      .out_root  (sq_root[g+1]),
      .out_side  (sq_side[g+1])
    );
  end

  // Compare stage: degenerate test and scaled numerators
  logic [R-1:0]            norm;
  logic [2:0][NW-1:0]      num;
  logic                    degen;
  logic                    c_valid;
  logic [2:0][M:0]         c_rem;
  logic [2:0][QW-1:0]      c_low;
  logic [R-1:0]            c_norm;
  tun_flags_t              c_flags;

  assign norm  = sq_root[R];
  assign degen = (norm == '0) || (CW'(norm) < CW'(min_norm));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = {sq_side[R][k*M +: M], {QW{1'b0}}} - {{QW{1'b0}}, sq_side[R][k*M +: M]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= sq_valid[R];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c_rem[k] <= {1'b0, num[k][NW-1:QW]};
        c_low[k] <= num[k][QW-1:0];
      end
      c_norm        <= norm;
      c_flags.degen <= degen;
      c_flags.neg   <= sq_side[R][3*M +: 3];
    end
  end

  // Divider chain
  logic                dv_valid [QW+1];
  logic [2:0][M:0]     dv_rem   [QW+1];
  logic [2:0][QW-1:0]  dv_low   [QW+1];
  logic [2:0][QW-1:0]  dv_quot  [QW+1];
  logic [R-1:0]        dv_norm  [QW+1];
  tun_flags_t          dv_flags [QW+1];

  assign dv_valid[0] = c_valid;
  assign dv_rem[0]   = c_rem;
  assign dv_low[0]   = c_low;
  assign dv_quot[0]  = '0;
  assign dv_norm[0]  = c_norm;
  assign dv_flags[0] = c_flags;

  for (genvar g = 0; g < QW; g++) begin : g_div
    tun_div_cell #(.NORM_BITS(R), .QUOT_BITS(QW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_valid[g]),
      .in_rem    (dv_rem[g]),
      .in_low    (dv_low[g]),
      .in_quot   (dv_quot[g]),
      .in_norm   (dv_norm[g]),
      .in_flags  (dv_flags[g]),
      .out_valid (dv_valid[g+1]),
      .out_rem   (dv_rem[g+1]),
      .out_low   (dv_low[g+1]),
      .out_quot  (dv_quot[g+1]),
      .out_norm  (dv_norm[g+1]),
      .out_flags (dv_flags[g+1])
    );
  end

  // Output register: sign restore, zero vector when degenerate
  logic [2:0][OUT_BITS-1:0] comp;
  tun_flags_t               fin;

  assign fin = dv_flags[QW];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (fin.degen) begin
        comp[k] = '0;
      end else if (fin.neg[k]) begin
        comp[k] = -{1'b0, dv_quot[QW][k]};
      end else begin
        comp[k] = {1'b0, dv_quot[QW][k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm.valid <= 1'b0;
    end else if (en) begin
      nrm.valid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm.normal_x   <= comp[0];
      nrm.normal_y   <= comp[1];
      nrm.normal_z   <= comp[2];
      nrm.degenerate <= fin.degen;
    end
  end

  // Checks
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    nrm.valid && nrm.degenerate |->
      nrm.normal_x == '0 && nrm.normal_y == '0 && nrm.normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    nrm.valid && !nrm.degenerate |->
      nrm.normal_x != NEG_LIMIT && nrm.normal_y != NEG_LIMIT && nrm.normal_z != NEG_LIMIT)
    else $error("normal component beyond scale");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(sq_root[R]) && $stable(dv_quot[QW]))
    else $error("pipeline moved during output stall");

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for triangle_unit_normal (unit face normal per triangle).
// Depends on tun_pkg, tun_ifs and the RTL; predicts each normal and compares in order.
`timescale 1ns / 1ps
module tb_top;
  import tun_pkg::*;

  localparam int CB = 16;
  localparam int OB = 16;
  localparam int LATENCY = 2 * CB + OB + 9;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [OB-1:0] SCALE = OB'((1 << (OB - 1)) - 1);

  typedef struct packed {
    logic signed [OB-1:0] nx, ny, nz;
    logic                 degen;
  } normal_t;

  typedef logic signed [CB-1:0] coord_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  tun_vtx_if #(.COORD_BITS(CB)) vtx ();
  tun_nrm_if #(.OUT_BITS(OB))   nrm ();
  tun_cfg_if                    cfg ();

  triangle_unit_normal #(.COORD_BITS(CB), .OUT_BITS(OB)) dut (
    .clk(clk), .rst(rst), .vtx(vtx.sink), .nrm(nrm.source), .cfg(cfg.sink)
  );

  logic [31:0] min_norm_model;
  normal_t     normals_due[$];
  int          mismatches = 0;
  int          idle_pct_src = 0;
  int          stall_pct_snk = 0;
  int          quiet_cycles = 0;

  // Predictor: exact integer cross product, floor sqrt, scaled truncating divide
  function automatic logic [63:0] floor_sqrt(logic [127:0] s);
    logic [63:0] lo, hi, mid;
    lo = 0;
    hi = 64'd1 << 51;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      if ({64'd0, mid} * {64'd0, mid} <= s) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [OB-1:0] scaled_comp(logic signed [63:0] c, logic [63:0] n);
    logic [127:0] q;
    logic [63:0]  m;
    m = c < 0 ? -c : c;
    q = ({64'd0, m} * SCALE) / n;
    if (q > SCALE) q = SCALE;
    return c < 0 ? -q[OB-1:0] : q[OB-1:0];
  endfunction

  function automatic normal_t face_normal(coord_t p[9]);
    logic signed [63:0] x1, x2, x3, y1, y2, y3, a, b, c;
    logic [63:0]        ma, mb, mc;
    logic [127:0]       s;
    logic [63:0]        n;
    normal_t            r;
    x1 = p[3] - p[0]; x2 = p[4] - p[1]; x3 = p[5] - p[2];
    y1 = p[6] - p[0]; y2 = p[7] - p[1]; y3 = p[8] - p[2];
    a = x2 * y3 - x3 * y2;
    b = x3 * y1 - x1 * y3;
    c = x1 * y2 - x2 * y1;
    // squares reach past 64 bits, so square the magnitudes at full width
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    mc = c < 0 ? -c : c;
    s = {64'd0, ma} * {64'd0, ma} + {64'd0, mb} * {64'd0, mb} + {64'd0, mc} * {64'd0, mc};
    n = floor_sqrt(s);
    if (n == 0 || n < {32'd0, min_norm_model}) begin
      r = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
    end else begin
      r.nx = scaled_comp(a, n);
      r.ny = scaled_comp(b, n);
      r.nz = scaled_comp(c, n);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  // Send one triangle, with random idle cycles before it
  task automatic send_triangle(coord_t p[9]);
    while ($urandom_range(99) < idle_pct_src) begin
      vtx.valid <= 1'b0;
      @(posedge clk);
    end
    vtx.valid <= 1'b1;
    {vtx.v0_x, vtx.v0_y, vtx.v0_z} <= {p[0], p[1], p[2]};
    {vtx.v1_x, vtx.v1_y, vtx.v1_z} <= {p[3], p[4], p[5]};
    {vtx.v2_x, vtx.v2_y, vtx.v2_z} <= {p[6], p[7], p[8]};
    @(posedge clk);
    while (!vtx.ready) @(posedge clk);
    normals_due.push_back(face_normal(p));
  endtask

  task automatic go_quiet();
    vtx.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    go_quiet();
    while (normals_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_min_norm(logic [31:0] v);
    drain();
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    min_norm_model = v;
    @(posedge clk);
  endtask

  function automatic coord_t rnd_coord(int span);
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return coord_t'($urandom);
      default: return coord_t'($signed($urandom_range(2 * span)) - span);
    endcase
  endfunction

  task automatic random_triangles(int count);
    coord_t p[9];
    int     span;
    repeat (count) begin
      span = $urandom_range(3) == 0 ? 32767 : (1 << $urandom_range(14));
      foreach (p[i]) p[i] = rnd_coord(span);
      case ($urandom_range(9))
        0: for (int i = 3; i < 6; i++) p[i] = p[i - 3];        // coincident vertices
        1: for (int i = 6; i < 9; i++) p[i] = p[i - 6] + (p[i - 3] - p[i - 6]); // collinear
        default: ;
      endcase
      send_triangle(p);
    end
  endtask

  // Directed extremes: zero area, largest span, unit axes, sign combos
  task automatic test_directed();
    coord_t p[9];
    foreach (p[i]) p[i] = 0;
    send_triangle(p);
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(p);
    p = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
    send_triangle(p);
    p = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
    send_triangle(p);
    p = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
    send_triangle(p);
    p = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
    send_triangle(p);
    p = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767};
    send_triangle(p);
    p = '{5, 5, 5, 5, 5, 5, 9, 9, 9};
    send_triangle(p);
    p = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
    send_triangle(p);
    p = '{0, 0, 0, 3, 0, 0, 0, 4, 0};
    send_triangle(p);
    p = '{-1, -1, -1, 0, 0, 0, -1, 0, -1};
    send_triangle(p);
    p = '{0, 0, 0, 32767, 1, 0, 1, 32767, 0};
    send_triangle(p);
  endtask

  task automatic test_min_norm_sweep();
    write_min_norm(32'd0);
    test_directed();
    random_triangles(100);
    write_min_norm(32'd10);
    random_triangles(100);
    write_min_norm(32'd5000);
    random_triangles(150);
    write_min_norm(32'hFFFF_FFFF);
    random_triangles(60);
    write_min_norm(32'd1);
  endtask

  task automatic test_idle_phases();
    idle_pct_src = 0;  stall_pct_snk = 0;  random_triangles(330);
    idle_pct_src = 58; stall_pct_snk = 0;  random_triangles(330);
    idle_pct_src = 0;  stall_pct_snk = 58; random_triangles(330);
    idle_pct_src = 23; stall_pct_snk = 23; random_triangles(330);
    idle_pct_src = 0;  stall_pct_snk = 0;
  endtask

  // Result sink: random back-pressure, compare against oldest prediction
  always @(posedge clk) begin
    normal_t got, want;
    if (rst) begin
      nrm.ready <= 1'b0;
    end else begin
      if (nrm.valid && nrm.ready) begin
        got = '{nx: nrm.normal_x, ny: nrm.normal_y, nz: nrm.normal_z,
                degen: nrm.degenerate};
        if (normals_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected normal transaction %p", got);
        end else begin
          want = normals_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("normal mismatch: expected %p actual %p", want, got);
          end
        end
      end
      nrm.ready <= $urandom_range(99) >= stall_pct_snk;
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((vtx.valid && vtx.ready) || (nrm.valid && nrm.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    vtx.valid <= 1'b0;
    {vtx.v0_x, vtx.v0_y, vtx.v0_z, vtx.v1_x, vtx.v1_y, vtx.v1_z} <= '0;
    {vtx.v2_x, vtx.v2_y, vtx.v2_z} <= '0;
    cfg.valid <= 1'b0;
    cfg.data  <= '0;
    min_norm_model = MIN_NORM_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_min_norm_sweep();
    test_idle_phases();
    drain();
    if (mismatches == 0 && normals_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/core/tun_pkg.sv
rtl/core/tun_ifs.sv
rtl/core/tun_front.sv
rtl/core/tun_sqrt_cell.sv
rtl/core/tun_div_cell.sv
rtl/core/triangle_unit_normal.sv
bench/tb_top.sv
